### rtl/core/hvt_pkg.sv
// ----------------------------------------------------------------------------
// hvt_pkg
// Shared types and constants for the homogeneous vector transform.
// ----------------------------------------------------------------------------
`default_nettype none

package hvt_pkg;

    localparam int LANES     = 4;
    localparam int DATA_W    = 32;
    localparam int PROD_W    = 2 * DATA_W;
    // four full-precision products summed
    localparam int SUM_W     = PROD_W + 2;
    localparam int CFG_W     = 64;
    localparam int CFG_IDX_W = 8;

    // coefficient value of 1.0 loaded on reset (fixed register encoding)
    localparam logic [DATA_W-1:0] COEF_ONE = 32'h0001_0000;
    localparam logic [DATA_W-1:0] SAT_MAX  = 32'h7FFF_FFFF;
    localparam logic [DATA_W-1:0] SAT_MIN  = 32'h8000_0000;

    typedef logic [LANES-1:0][DATA_W-1:0] hvt_vec_t;
    typedef logic [LANES-1:0][SUM_W-1:0]  hvt_psum_t;

    // one beat traveling down the cell row
    typedef struct packed {
        hvt_vec_t  vec;
        hvt_psum_t psum;
    } hvt_beat_t;

endpackage

`default_nettype wire

### rtl/core/hvt_cell.sv
// ----------------------------------------------------------------------------
// hvt_cell
// One column cell: holds one matrix column, multiplies it by its vector
// component and adds the products to the partial row sums passing through.
// ----------------------------------------------------------------------------
`default_nettype none

module hvt_cell #(
    parameter int COL = 0
) (
    input  wire                           aclk,
    input  wire                           aresetn,
    input  wire                           cfg_we,
    input  wire [hvt_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire [hvt_pkg::CFG_W-1:0]      cfg_wdata,
    input  wire                           in_valid,
    output logic                          in_ready,
    input  hvt_pkg::hvt_beat_t            in_beat,
    output logic                          out_valid,
    input  wire                           out_ready,
    output hvt_pkg::hvt_beat_t            out_beat
);
    import hvt_pkg::*;

    localparam int REG_HALF = COL / 2;
    localparam int HI_WORD  = COL % 2;

    logic [DATA_W-1:0]              coef_reg [LANES];
    logic [LANES-1:0][PROD_W-1:0]   prod_reg;
    logic [LANES-1:0][PROD_W-1:0]   prod_next;
    hvt_beat_t                      a_beat_reg;
    hvt_beat_t                      b_beat_reg;
    hvt_beat_t                      b_beat_next;
    logic                           a_valid_reg;
    logic                           b_valid_reg;
    logic                           a_ready;
    logic                           b_ready;

    assign b_ready   = !b_valid_reg || out_ready;
    assign a_ready   = !a_valid_reg || b_ready;
    assign in_ready  = a_ready;
    assign out_valid = b_valid_reg;
    assign out_beat  = b_beat_reg;

    // column coefficients, one per row
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int r = 0; r < LANES; r++) begin
                coef_reg[r] <= (r == COL) ? COEF_ONE : '0;
            end
        end else if (cfg_we) begin
            for (int r = 0; r < LANES; r++) begin
                if (cfg_index == CFG_IDX_W'(2 * r + REG_HALF)) begin
                    coef_reg[r] <= (HI_WORD == 1) ? cfg_wdata[CFG_W-1:DATA_W]
                                                  : cfg_wdata[DATA_W-1:0];
                end
            end
        end
    end

    always_comb begin
        for (int r = 0; r < LANES; r++) begin
            prod_next[r] = PROD_W'($signed(coef_reg[r]) * $signed(in_beat.vec[COL]));
        end
    end

    always_comb begin
        b_beat_next.vec = a_beat_reg.vec;
        for (int r = 0; r < LANES; r++) begin
            b_beat_next.psum[r] = SUM_W'($signed(a_beat_reg.psum[r])
                                         + $signed({{2{prod_reg[r][PROD_W-1]}}, prod_reg[r]}));
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
        end else begin
            if (a_ready) begin
                a_valid_reg <= in_valid;
            end
            if (b_ready) begin
                b_valid_reg <= a_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (a_ready && in_valid) begin
            prod_reg   <= prod_next;
            a_beat_reg <= in_beat;
        end
        if (b_ready && a_valid_reg) begin
            b_beat_reg <= b_beat_next;
        end
    end

`ifndef NO_ASSERTIONS
    a_load_check: assert property (@(posedge aclk) disable iff (!aresetn)
        in_valid && in_ready |=> a_valid_reg)
        else $error("cell dropped an accepted beat");
    a_hold_check: assert property (@(posedge aclk) disable iff (!aresetn)
        a_valid_reg && !b_ready |=> a_valid_reg && $stable(prod_reg))
        else $error("product stage lost data while stalled");
    b_hold_check: assert property (@(posedge aclk) disable iff (!aresetn)
        b_valid_reg && !out_ready |=> b_valid_reg && $stable(b_beat_reg))
        else $error("sum stage lost data while stalled");
`endif

endmodule

`default_nettype wire

### rtl/core/hvt_sat.sv
// ----------------------------------------------------------------------------
// hvt_sat
// Output stage: scales the row sums down and clips them to 32 bits.
// ----------------------------------------------------------------------------
`default_nettype none

module hvt_sat #(
    parameter int FRACTION_BITS = 16
) (
    input  wire                                        aclk,
    input  wire                                        aresetn,
    input  wire                                        in_valid,
    output logic                                       in_ready,
    input  hvt_pkg::hvt_psum_t                         in_psum,
    output logic                                       out_valid,
    input  wire                                        out_ready,
    output logic [hvt_pkg::LANES-1:0][hvt_pkg::DATA_W-1:0] out_data,
    output logic                                       out_saturated
);
    import hvt_pkg::*;

    logic [LANES-1:0][DATA_W-1:0] data_reg;
    logic [LANES-1:0][DATA_W-1:0] data_next;
    logic                         sat_reg;
    logic                         sat_next;
    logic                         valid_reg;
    logic [SUM_W-1:0]             shifted;
    logic [SUM_W-DATA_W:0]        upper;

    assign in_ready      = !valid_reg || out_ready;
    assign out_valid     = valid_reg;
    assign out_data      = data_reg;
    assign out_saturated = sat_reg;

    always_comb begin
        sat_next  = 1'b0;
        data_next = '0;
        shifted   = '0;
        upper     = '0;
        for (int r = 0; r < LANES; r++) begin
            shifted = SUM_W'($signed(in_psum[r]) >>> FRACTION_BITS);
            upper   = shifted[SUM_W-1:DATA_W-1];
            // clip unless all bits above the result sign match it
            if (upper == '0 || upper == '1) begin
                data_next[r] = shifted[DATA_W-1:0];
            end else begin
                data_next[r] = shifted[SUM_W-1] ? SAT_MIN : SAT_MAX;
                sat_next     = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            data_reg <= data_next;
            sat_reg  <= sat_next;
        end
    end

endmodule

`default_nettype wire

### rtl/core/homogeneous_vector_transform_top.sv
// An accepted input beat reaches the result beat through two register stages
// in each of the four column cells and one output stage.
// Throughput: one vector per cycle while m_ready is high; every stage
// carries its own valid bit, so a stalled result holds only the stages
// behind it until bubbles close. Reset (aresetn, synchronous, active low)
// empties the pipeline and loads the identity matrix.
// ----------------------------------------------------------------------------
// homogeneous_vector_transform_top
// 4x4 fixed-point matrix times homogeneous vector, as a row of column cells.
// ----------------------------------------------------------------------------
`default_nettype none

module homogeneous_vector_transform_top #(
    parameter int FRACTION_BITS = 16
) (
    input  wire                           aclk,
    input  wire                           aresetn,
    input  wire                           cfg_we,
    input  wire [hvt_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire [hvt_pkg::CFG_W-1:0]      cfg_wdata,
    input  wire                           s_valid,
    output logic                          s_ready,
    input  wire signed [31:0]             s_in_x,
    input  wire signed [31:0]             s_in_y,
    input  wire signed [31:0]             s_in_z,
    input  wire signed [31:0]             s_in_w,
    output logic                          m_valid,
    input  wire                           m_ready,
    output logic signed [31:0]            m_out_x,
    output logic signed [31:0]            m_out_y,
    output logic signed [31:0]            m_out_z,
    output logic signed [31:0]            m_out_w,
    output logic                          m_saturated
);
    import hvt_pkg::*;

    hvt_beat_t                    beat   [LANES+1];
    logic                         valid  [LANES+1];
    logic                         ready  [LANES+1];
    logic [LANES-1:0][DATA_W-1:0] result;

    assign beat[0]         = '{vec: {s_in_w, s_in_z, s_in_y, s_in_x}, psum: '0};
    assign valid[0]        = s_valid;
    assign s_ready         = ready[0];

    for (genvar c = 0; c < LANES; c++) begin : g_cell
        hvt_cell #(
            .COL (c)
        ) u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .cfg_we    (cfg_we),
            .cfg_index (cfg_index),
            .cfg_wdata (cfg_wdata),
            .in_valid  (valid[c]),
            .in_ready  (ready[c]),
            .in_beat   (beat[c]),
            .out_valid (valid[c+1]),
            .out_ready (ready[c+1]),
            .out_beat  (beat[c+1])
        );
    end

    hvt_sat #(
        .FRACTION_BITS (FRACTION_BITS)
    ) u_sat (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .in_valid      (valid[LANES]),
        .in_ready      (ready[LANES]),
        .in_psum       (beat[LANES].psum),
        .out_valid     (m_valid),
        .out_ready     (m_ready),
        .out_data      (result),
        .out_saturated (m_saturated)
    );

    assign m_out_x = result[0];
    assign m_out_y = result[1];
    assign m_out_z = result[2];
    assign m_out_w = result[3];

`ifndef NO_ASSERTIONS
    full_check: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> m_valid && !m_ready)
        else $error("input stalled while output is not stalled");
    clip_check: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_saturated |->
            (m_out_x == SAT_MAX || m_out_x == SAT_MIN ||
             m_out_y == SAT_MAX || m_out_y == SAT_MIN ||
             m_out_z == SAT_MAX || m_out_z == SAT_MIN ||
             m_out_w == SAT_MAX || m_out_w == SAT_MIN))
        else $error("clip flag set with no clipped component");
    reset_check: assert property (@(posedge aclk)
        $past(!aresetn) |-> !m_valid)
        else $error("result beat right after reset");
`endif

endmodule

`default_nettype wire

### bench/homogeneous_vector_transform_top_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// homogeneous_vector_transform_top_tb
// Streams Q16.16 vectors through the 4x4 transform under a series of matrices
// (identity, saturating extremes, zero, minus one LSB, random) and checks
// every result beat against an in-bench fixed-point prediction.
// ----------------------------------------------------------------------------

module homogeneous_vector_transform_top_tb;

    import hvt_pkg::*;

    localparam int FRAC_BITS        = 16;
    localparam int ITEMS_PER_PHASE  = 140;
    localparam int RANDOM_PHASES    = 14;
    localparam int NUM_DIRECTED     = 10;
    localparam int NUM_MATRIX_REGS  = 8;
    localparam int LAST_CFG_INDEX   = 2 ** CFG_IDX_W - 1;
    localparam int TAIL_CYCLES      = 30;
    localparam int CYCLE_LIMIT      = 1_000_000;

    localparam logic signed [SUM_W-1:0] SUM_TOP    = 66'sd2147483647;
    localparam logic signed [SUM_W-1:0] SUM_BOTTOM = -66'sd2147483648;

    typedef enum logic [CFG_IDX_W-1:0] {
        ROW0_LEFT = 0, ROW0_RIGHT, ROW1_LEFT, ROW1_RIGHT,
        ROW2_LEFT, ROW2_RIGHT, ROW3_LEFT, ROW3_RIGHT
    } matrix_reg_e;

    typedef struct packed {
        logic [LANES-1:0][DATA_W-1:0] comp;
        logic                         sat;
    } xform_t;

    class xform_scoreboard;
        logic [CFG_W-1:0] matrix_regs[NUM_MATRIX_REGS];
        xform_t           expected_xforms[$];
        int               errors;
        int               vectors;
        int               clipped;
        string            comp_names[LANES] = '{"out_x", "out_y", "out_z", "out_w"};

        function void reset_matrix();
            foreach (matrix_regs[i]) matrix_regs[i] = '0;
            matrix_regs[ROW0_LEFT]  = {32'h0, COEF_ONE};
            matrix_regs[ROW1_LEFT]  = {COEF_ONE, 32'h0};
            matrix_regs[ROW2_RIGHT] = {32'h0, COEF_ONE};
            matrix_regs[ROW3_RIGHT] = {COEF_ONE, 32'h0};
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
            // indexes past the matrix are dropped by the block
            if (idx < NUM_MATRIX_REGS) matrix_regs[idx] = data;
        endfunction

        function xform_t transform_vector(hvt_vec_t vec);
            xform_t                   res;
            logic signed [SUM_W-1:0]  acc;
            logic signed [SUM_W-1:0]  prod;
            logic signed [SUM_W-1:0]  shifted;
            logic [CFG_W-1:0]         word;
            logic signed [DATA_W-1:0] cf;
            res.sat = 1'b0;
            for (int r = 0; r < LANES; r++) begin
                acc = '0;
                for (int c = 0; c < LANES; c++) begin
                    word = matrix_regs[r * 2 + c / 2];
                    cf   = (c % 2 == 1) ? word[63:32] : word[31:0];
                    prod = cf * $signed(vec[c]);
                    acc  = acc + prod;
                end
                // arithmetic shift rounds toward minus infinity
                shifted = acc >>> FRAC_BITS;
                if (shifted > SUM_TOP) begin
                    res.comp[r] = SAT_MAX;
                    res.sat     = 1'b1;
                end else if (shifted < SUM_BOTTOM) begin
                    res.comp[r] = SAT_MIN;
                    res.sat     = 1'b1;
                end else begin
                    res.comp[r] = shifted[DATA_W-1:0];
                end
            end
            return res;
        endfunction

        function void note_vector(hvt_vec_t vec);
            xform_t want;
            want = transform_vector(vec);
            expected_xforms.push_back(want);
            vectors++;
            if (want.sat) clipped++;
        endfunction

        function void check_result(xform_t got);
            xform_t want;
            if (expected_xforms.size() == 0) begin
                $error("result beat with no vector outstanding");
                errors++;
                return;
            end
            want = expected_xforms.pop_front();
            for (int i = 0; i < LANES; i++) begin
                if (got.comp[i] !== want.comp[i]) begin
                    $error("%s: expected %h, got %h", comp_names[i], want.comp[i],
                           got.comp[i]);
                    errors++;
                end
            end
            if (got.sat !== want.sat) begin
                $error("saturated: expected %b, got %b", want.sat, got.sat);
                errors++;
            end
        endfunction

        function int pending();
            return expected_xforms.size();
        endfunction
    endclass

    logic                     aclk = 1'b0;
    logic                     aresetn;
    logic                     cfg_we;
    logic [CFG_IDX_W-1:0]     cfg_index;
    logic [CFG_W-1:0]         cfg_wdata;
    logic                     s_valid;
    logic                     s_ready;
    logic signed [31:0]       s_in_x, s_in_y, s_in_z, s_in_w;
    logic                     m_valid;
    logic                     m_ready;
    logic signed [31:0]       m_out_x, m_out_y, m_out_z, m_out_w;
    logic                     m_saturated;

    xform_scoreboard sb;
    bit              calm;
    int              cycle_count = 0;

    homogeneous_vector_transform_top #(
        .FRACTION_BITS(FRAC_BITS)
    ) dut (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_wdata  (cfg_wdata),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_in_x     (s_in_x),
        .s_in_y     (s_in_y),
        .s_in_z     (s_in_z),
        .s_in_w     (s_in_w),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_out_x    (m_out_x),
        .m_out_y    (m_out_y),
        .m_out_z    (m_out_z),
        .m_out_w    (m_out_w),
        .m_saturated(m_saturated)
    );

    always #1 aclk = ~aclk;

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // Mostly short gaps, now and then a long one; none during calm phases.
    function automatic int pick_gap();
        int roll;
        if (calm) return 0;
        roll = $urandom_range(0, 99);
        if (roll < 55) return 0;
        if (roll < 92) return $urandom_range(1, 3);
        return $urandom_range(4, 30);
    endfunction

    function automatic logic [31:0] pick_extreme();
        case ($urandom_range(0, 4))
            0:       return SAT_MAX;
            1:       return SAT_MIN;
            2:       return 32'h0;
            3:       return 32'hFFFF_FFFF;
            default: return COEF_ONE;
        endcase
    endfunction

    function automatic logic [31:0] pick_component();
        case ($urandom_range(0, 9))
            0:       return pick_extreme();
            1, 2, 3: return $urandom;
            default: return $urandom_range(0, 32'h0020_0000) - 32'h0010_0000;
        endcase
    endfunction

    function automatic logic [31:0] pick_coef();
        case ($urandom_range(0, 9))
            0:       return pick_extreme();
            1, 2:    return $urandom;
            default: return $urandom_range(0, 32'h0004_0000) - 32'h0002_0000;
        endcase
    endfunction

    // Result side: stall m_ready in bursts, accept and check at the rising edge.
    initial begin
        int stall_left;
        stall_left = 0;
        m_ready    = 1'b0;
        wait (aresetn === 1'b1);
        forever begin
            @(negedge aclk);
            if (stall_left > 0) begin
                m_ready <= 1'b0;
                stall_left--;
            end else begin
                m_ready <= 1'b1;
                stall_left = pick_gap();
            end
        end
    end

    always @(posedge aclk) begin
        xform_t got;
        if (aresetn && m_valid && m_ready) begin
            got.comp = {m_out_w, m_out_z, m_out_y, m_out_x};
            got.sat  = m_saturated;
            sb.check_result(got);
        end
    end

    // Called and returns at a falling edge; leaves s_valid high after the beat.
    task automatic send_vec(input hvt_vec_t vec);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_in_x  <= vec[0];
        s_in_y  <= vec[1];
        s_in_z  <= vec[2];
        s_in_w  <= vec[3];
        do @(posedge aclk); while (!s_ready);
        sb.note_vector(vec);
        @(negedge aclk);
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        while (sb.pending() != 0) @(negedge aclk);
    endtask

    task automatic write_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        sb.write_reg(idx, data);
        @(negedge aclk);
    endtask

    // Write all eight matrix registers plus one stray index that must be ignored.
    task automatic load_matrix(input logic [CFG_W-1:0] regs[NUM_MATRIX_REGS],
                               input logic [CFG_IDX_W-1:0] stray_index);
        for (int i = 0; i < NUM_MATRIX_REGS; i++) write_cfg(CFG_IDX_W'(i), regs[i]);
        write_cfg(stray_index, {$urandom, $urandom});
        cfg_we <= 1'b0;
        @(negedge aclk);
    endtask

    initial begin
        logic [31:0]      directed_vecs[NUM_DIRECTED][LANES];
        logic [CFG_W-1:0] mat[NUM_MATRIX_REGS];
        hvt_vec_t         vec;
        int               settings;

        directed_vecs = '{
            '{32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000},
            '{32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF},
            '{32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000},
            '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF},
            '{32'h0000_0001, 32'h0000_0001, 32'h0000_0001, 32'h0000_0001},
            '{32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000},
            '{32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF},
            '{32'h0001_0000, 32'hFFFF_0000, 32'h0000_8000, 32'hFFFF_8000},
            '{32'hFFFF_FFFF, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000},
            '{32'h0000_FFFF, 32'hFFFF_0001, 32'h5555_5555, 32'hAAAA_AAAA}
        };

        sb = new();
        sb.reset_matrix();
        calm      = 1'b0;
        aresetn   = 1'b0;
        cfg_we    = 1'b0;
        cfg_index = '0;
        cfg_wdata = '0;
        s_valid   = 1'b0;
        s_in_x    = '0;
        s_in_y    = '0;
        s_in_z    = '0;
        s_in_w    = '0;
        settings  = 1;

        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // identity after reset: extremes pass straight through
        for (int d = 0; d < NUM_DIRECTED; d++) begin
            for (int k = 0; k < LANES; k++) vec[k] = directed_vecs[d][k];
            send_vec(vec);
        end
        drain();

        // row 0 saturates high, row 1 low, row 2 shows floor rounding of tiny
        // products, row 3 mixes +1.0, -1.0, 0 and 0.5
        mat[ROW0_LEFT]  = {SAT_MAX, SAT_MAX};
        mat[ROW0_RIGHT] = {SAT_MAX, SAT_MAX};
        mat[ROW1_LEFT]  = {SAT_MIN, SAT_MIN};
        mat[ROW1_RIGHT] = {SAT_MIN, SAT_MIN};
        mat[ROW2_LEFT]  = {32'h0000_0001, 32'h0000_0001};
        mat[ROW2_RIGHT] = {32'h0000_0001, 32'h0000_0001};
        mat[ROW3_LEFT]  = {32'hFFFF_0000, COEF_ONE};
        mat[ROW3_RIGHT] = {32'h0000_8000, 32'h0000_0000};
        load_matrix(mat, CFG_IDX_W'(NUM_MATRIX_REGS));
        settings++;
        for (int d = 0; d < NUM_DIRECTED; d++) begin
            for (int k = 0; k < LANES; k++) vec[k] = directed_vecs[d][k];
            send_vec(vec);
        end
        drain();

        for (int phase = 1; phase <= RANDOM_PHASES; phase++) begin
            calm = ($urandom_range(0, 3) == 0);
            for (int i = 0; i < NUM_MATRIX_REGS; i++) begin
                case (phase)
                    1:       mat[i] = {SAT_MAX, SAT_MAX};
                    2:       mat[i] = {SAT_MIN, SAT_MIN};
                    3:       mat[i] = '0;
                    4:       mat[i] = '1;
                    default: mat[i] = {pick_coef(), pick_coef()};
                endcase
            end
            load_matrix(mat, CFG_IDX_W'((phase == 1) ? LAST_CFG_INDEX
                                 : $urandom_range(NUM_MATRIX_REGS, LAST_CFG_INDEX)));
            settings++;
            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                for (int k = 0; k < LANES; k++) vec[k] = pick_component();
                send_vec(vec);
            end
            drain();
        end

        // hold a little longer to catch any stray result beat
        repeat (TAIL_CYCLES) @(negedge aclk);

        $display("Transformed %0d vectors under %0d matrix settings, %0d with a clipped lane.",
                 sb.vectors, settings, sb.clipped);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("%0d mismatches, %0d results missing", sb.errors, sb.pending());
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
